// ===== rtl/core/cor_pkg.sv =====
// shared types, state and operation codes, saturation helper for the overlap relaxation block
package cor_pkg;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic        [15:0] radius;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic               out_last;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_READ, OP_DIFF, OP_SQX, OP_SQY, OP_RS2, OP_CMP,
        OP_SQRT, OP_OVL, OP_DEN1, OP_DEN2, OP_CR, OP_NUML, OP_NUMH,
        OP_DIVI, OP_DIV, OP_MOVE, OP_WRI, OP_WRJ
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NEXT, ST_READ, ST_DIFF, ST_SQX, ST_SQY, ST_RS2, ST_CMP,
        ST_CHK, ST_SQRT, ST_OVL, ST_DEN1, ST_DEN2, ST_CR, ST_NUML, ST_NUMH,
        ST_DIVI, ST_DIV, ST_MOVE, ST_WRI, ST_WRJ, ST_ERD, ST_EOUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] comp;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic hit;
    } status_t;

    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 24;
    localparam logic signed [25:0] POS_MAX = 26'sd8388607;
    localparam logic signed [25:0] POS_MIN = -26'sd8388608;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > POS_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < POS_MIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cor_datapath.sv =====
// coordinate stores, pair arithmetic, square root and divider
module cor_datapath
    import cor_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int IW = $clog2(MAX_PARTICLES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cmd_t            cmd,
    input  logic [IW-1:0]   addr_a,
    input  logic [IW-1:0]   addr_b,
    input  in_item_t        item,
    output status_t         status,
    output out_item_t       result
);

    logic signed [23:0] x_mem [MAX_PARTICLES];
    logic signed [23:0] y_mem [MAX_PARTICLES];
    logic        [15:0] r_mem [MAX_PARTICLES];

    logic signed [23:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic        [15:0] ra_reg, rb_reg;
    logic               sx_reg, sy_reg;
    logic        [24:0] adx_reg, ady_reg;
    logic        [16:0] rs_reg;
    logic        [48:0] px_reg, py_reg;
    logic        [33:0] rs2_reg;
    logic               hit_reg;
    logic        [49:0] sv_reg, sres_reg, sbit_reg;
    logic        [24:0] ovl_reg;
    logic        [41:0] dr_reg;
    logic        [45:0] den_reg;
    logic        [32:0] cr_reg;
    logic        [57:0] num_reg;
    logic        [59:0] rem_reg;
    logic        [69:0] ds_reg;
    logic        [23:0] q_reg;
    logic signed [24:0] mv_reg [4];

    logic        [49:0] d2;
    logic        [49:0] strial;
    logic        [16:0] cmag;
    logic        [15:0] rsel;
    logic               csign;
    logic        [69:0] rem_ext;
    logic        [45:0] numh;
    logic        [24:0] qext;
    logic signed [24:0] mv_next;

    assign d2      = {1'b0, px_reg} + {1'b0, py_reg};
    assign strial  = sres_reg + sbit_reg;
    assign cmag    = cmd.comp[0] ? ady_reg[16:0] : adx_reg[16:0];
    assign rsel    = cmd.comp[1] ? ra_reg : rb_reg;
    assign csign   = cmd.comp[0] ? sy_reg : sx_reg;
    assign rem_ext = {10'b0, rem_reg};
    assign numh    = cr_reg * ovl_reg[24:13];
    assign qext    = {1'b0, q_reg};
    assign mv_next = csign ? -$signed(qext) : $signed(qext);

    // stores: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_mem[addr_a] <= item.pos_x;
                y_mem[addr_a] <= item.pos_y;
                r_mem[addr_a] <= item.radius;
            end
            OP_WRI:
            begin
                x_mem[addr_a] <= sat24({{2{xa_reg[23]}}, xa_reg} + {mv_reg[0][24], mv_reg[0]});
                y_mem[addr_a] <= sat24({{2{ya_reg[23]}}, ya_reg} + {mv_reg[1][24], mv_reg[1]});
            end
            OP_WRJ:
            begin
                x_mem[addr_b] <= sat24({{2{xb_reg[23]}}, xb_reg} - {mv_reg[2][24], mv_reg[2]});
                y_mem[addr_b] <= sat24({{2{yb_reg[23]}}, yb_reg} - {mv_reg[3][24], mv_reg[3]});
            end
            default:
            begin
            end
        endcase
        xa_reg <= x_mem[addr_a];
        ya_reg <= y_mem[addr_a];
        ra_reg <= r_mem[addr_a];
        xb_reg <= x_mem[addr_b];
        yb_reg <= y_mem[addr_b];
        rb_reg <= r_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.op == OP_CMP)
        begin
            hit_reg <= (d2 != 50'd0) && (d2 < {16'd0, rs2_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_DIFF:
            begin
                sx_reg  <= xa_reg < xb_reg;
                sy_reg  <= ya_reg < yb_reg;
                adx_reg <= (xa_reg < xb_reg) ? 25'($signed(xb_reg) - $signed(xa_reg))
                                             : 25'($signed(xa_reg) - $signed(xb_reg));
                ady_reg <= (ya_reg < yb_reg) ? 25'($signed(yb_reg) - $signed(ya_reg))
                                             : 25'($signed(ya_reg) - $signed(yb_reg));
                rs_reg  <= {1'b0, ra_reg} + {1'b0, rb_reg};
            end
            OP_SQX:  px_reg  <= 49'(adx_reg * adx_reg);
            OP_SQY:  py_reg  <= 49'(ady_reg * ady_reg);
            OP_RS2:  rs2_reg <= rs_reg * rs_reg;
            OP_CMP:
            begin
                sv_reg   <= {d2[33:0], 16'd0};
                sres_reg <= 50'd0;
                sbit_reg <= 50'd1 << 48;
            end
            OP_SQRT:
            begin
                if (sv_reg >= strial)
                begin
                    sv_reg   <= sv_reg - strial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_OVL:  ovl_reg <= {rs_reg, 8'd0} - sres_reg[24:0];
            OP_DEN1: dr_reg  <= sres_reg[24:0] * rs_reg;
            OP_DEN2: den_reg <= {1'b0, dr_reg, 3'd0} + {3'd0, dr_reg, 1'b0};
            OP_CR:   cr_reg  <= cmag * rsel;
            OP_NUML: num_reg <= 58'(cr_reg * ovl_reg[12:0]);
            OP_NUMH: num_reg <= num_reg + {numh[44:0], 13'd0};
            OP_DIVI:
            begin
                rem_reg <= {1'b0, num_reg, 1'b0} + {14'd0, den_reg};
                ds_reg  <= {den_reg, 1'b0, 23'd0};
                q_reg   <= 24'd0;
            end
            OP_DIV:
            begin
                if (rem_ext >= ds_reg)
                begin
                    rem_reg <= rem_reg - ds_reg[59:0];
                    q_reg   <= {q_reg[22:0], 1'b1};
                end
                else
                begin
                    q_reg   <= {q_reg[22:0], 1'b0};
                end
                ds_reg <= ds_reg >> 1;
            end
            OP_MOVE: mv_reg[cmd.comp] <= mv_next;
            default:
            begin
            end
        endcase
    end

    assign status.hit      = hit_reg;
    assign result.out_x    = xa_reg;
    assign result.out_y    = ya_reg;
    assign result.out_last = cmd.out_last;

endmodule

// ===== rtl/core/cor_ctrl.sv =====
// sequencer: load count, pair loop, micro-steps of one pair, emission
module cor_ctrl
    import cor_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int IW = $clog2(MAX_PARTICLES),
    parameter int CW = $clog2(MAX_PARTICLES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          item_last,
    input  status_t       status,
    output logic          busy,
    output logic          strobe,
    output cmd_t          cmd,
    output logic [IW-1:0] addr_a,
    output logic [IW-1:0] addr_b
);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   e_reg, e_next;
    logic [4:0]      step_reg, step_next;
    logic [1:0]      m_reg, m_next;
    logic            room;
    logic            e_last;

    assign room   = count_reg < CW'(MAX_PARTICLES);
    assign e_last = e_reg == (count_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            e_reg     <= '0;
            step_reg  <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            e_reg     <= e_next;
            step_reg  <= step_next;
            m_reg     <= m_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        e_next     = e_reg;
        step_next  = step_reg;
        m_next     = m_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (item_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                if (i_reg == count_reg)
                begin
                    e_next     = '0;
                    state_next = ST_ERD;
                end
                else if (j_reg == count_reg)
                begin
                    i_next = i_reg + CW'(1);
                    j_next = '0;
                end
                else if (i_reg == j_reg)
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_RS2;
            ST_RS2:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_CHK;
            ST_CHK:
            begin
                step_next = '0;
                if (status.hit)
                begin
                    state_next = ST_SQRT;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_NEXT;
                end
            end
            ST_SQRT:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = ST_OVL;
                end
            end
            ST_OVL:
            begin
                m_next     = '0;
                state_next = ST_DEN1;
            end
            ST_DEN1: state_next = ST_DEN2;
            ST_DEN2: state_next = ST_CR;
            ST_CR:   state_next = ST_NUML;
            ST_NUML: state_next = ST_NUMH;
            ST_NUMH: state_next = ST_DIVI;
            ST_DIVI:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                m_next     = m_reg + 2'd1;
                state_next = (m_reg == 2'd3) ? ST_WRI : ST_CR;
            end
            ST_WRI:  state_next = ST_WRJ;
            ST_WRJ:
            begin
                j_next     = j_reg + CW'(1);
                state_next = ST_NEXT;
            end
            ST_ERD:  state_next = ST_EOUT;
            ST_EOUT:
            begin
                if (e_last)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_next     = e_reg + CW'(1);
                    state_next = ST_ERD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.comp     = m_reg;
        cmd.out_last = 1'b0;
        addr_a       = i_reg[IW-1:0];
        addr_b       = j_reg[IW-1:0];
        busy         = 1'b1;
        strobe       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy   = 1'b0;
                addr_a = count_reg[IW-1:0];
                if (start && room)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_READ: cmd.op = OP_READ;
            ST_DIFF: cmd.op = OP_DIFF;
            ST_SQX:  cmd.op = OP_SQX;
            ST_SQY:  cmd.op = OP_SQY;
            ST_RS2:  cmd.op = OP_RS2;
            ST_CMP:  cmd.op = OP_CMP;
            ST_SQRT: cmd.op = OP_SQRT;
            ST_OVL:  cmd.op = OP_OVL;
            ST_DEN1: cmd.op = OP_DEN1;
            ST_DEN2: cmd.op = OP_DEN2;
            ST_CR:   cmd.op = OP_CR;
            ST_NUML: cmd.op = OP_NUML;
            ST_NUMH: cmd.op = OP_NUMH;
            ST_DIVI: cmd.op = OP_DIVI;
            ST_DIV:  cmd.op = OP_DIV;
            ST_MOVE: cmd.op = OP_MOVE;
            ST_WRI:  cmd.op = OP_WRI;
            ST_WRJ:  cmd.op = OP_WRJ;
            ST_ERD:  addr_a = e_reg[IW-1:0];
            ST_EOUT:
            begin
                addr_a       = e_reg[IW-1:0];
                strobe       = 1'b1;
                cmd.out_last = e_last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/circle_overlap_relaxation.sv =====
// top level of the circle overlap relaxation block
//
//  channel | handshake       | beat       | notes
//  input   | start / busy    | item       | taken when start high and busy low
//  output  | strobe          | result     | one cycle per beat, cannot be held off
//
// loading takes one circle per cycle while idle; the beat with last set starts the pass
// the pass walks every ordered pair: a skipped index only advances the loop, a
// pair that does not touch runs read, difference, squares, compare and check,
// a touching pair adds the 25-step square root and four 24-step restoring
// divisions in the shared datapath; emission: registered read, then strobe
// asynchronous active-low reset empties the set; the stores are not cleared
module circle_overlap_relaxation
    import cor_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      strobe,
    output out_item_t result
);

    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    // command and status between sequencer and datapath
    cmd_t          cmd;
    status_t       status;
    logic [IW-1:0] addr_a;
    logic [IW-1:0] addr_b;

    cor_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .IW            (IW),
        .CW            (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item.last),
        .status    (status),
        .busy      (busy),
        .strobe    (strobe),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b)
    );

    cor_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .IW            (IW)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .item   (item),
        .status (status),
        .result (result)
    );

    // results only come out during a pass
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat outside a pass");

    // a beat without last never starts a pass
    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("block went busy on a plain load");

    // the final result ends the pass
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.out_last) |=> (!busy && !strobe))
        else $error("block still busy after final result");

    // a last beat always leads to a pass
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last) |=> busy)
        else $error("pass did not start");

endmodule

// ===== test/tb_circle_overlap_relaxation.sv =====
// self-checking testbench for the circle overlap relaxation block
`timescale 1ns / 100ps

module tb_circle_overlap_relaxation;
    import cor_pkg::*;

    localparam int SET_DEPTH   = 64;
    // the limit lies well above the time a full set of touching circles keeps the block busy
    localparam int STALL_LIMIT = 2000000;
    localparam int SETTLE      = 200;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      strobe;
    out_item_t result;

    // predictor copy of the block's stores
    logic signed [23:0] mirror_x [SET_DEPTH];
    logic signed [23:0] mirror_y [SET_DEPTH];
    logic        [15:0] mirror_r [SET_DEPTH];
    int                 mirror_count;

    out_item_t relaxed_q[$];
    int        mismatches;
    int        stall_cycles;
    int        sender_idle_pct;
    bit        timed_out;

    circle_overlap_relaxation #(.MAX_PARTICLES(SET_DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor of the square root, built up one result bit at a time from the top
    function automatic longint floor_root(input longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // c * r * o / den, rounded to nearest with ties away from zero
    function automatic longint push_share(input longint c, input longint r,
                                          input longint o, input longint den);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q   = (2 * mag * r * o + den) / (2 * den);
        return (c < 0) ? -q : q;
    endfunction

    function automatic logic signed [23:0] clamp_pos(input longint v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -64'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    // one ordered pair; the moves land in the mirror at once
    task automatic separate_pair(input int i, input int j);
        longint dx, dy, ri, rj, rs, d2, centre_gap, ovl, den;
        longint mxi, myi, mxj, myj;
        dx = longint'(mirror_x[i]) - longint'(mirror_x[j]);
        dy = longint'(mirror_y[i]) - longint'(mirror_y[j]);
        ri = longint'(mirror_r[i]);
        rj = longint'(mirror_r[j]);
        rs = ri + rj;
        d2 = dx * dx + dy * dy;
        // coincident centres have no normal, and circles apart do not move
        if (d2 == 0 || d2 >= rs * rs)
        begin
            return;
        end
        centre_gap = floor_root(d2 << 16);
        ovl        = (rs << 8) - centre_gap;
        den        = centre_gap * rs * 10;
        mxi  = push_share(dx, rj, ovl, den);
        myi  = push_share(dy, rj, ovl, den);
        mxj  = push_share(dx, ri, ovl, den);
        myj  = push_share(dy, ri, ovl, den);
        mirror_x[i] = clamp_pos(longint'(mirror_x[i]) + mxi);
        mirror_y[i] = clamp_pos(longint'(mirror_y[i]) + myi);
        mirror_x[j] = clamp_pos(longint'(mirror_x[j]) - mxj);
        mirror_y[j] = clamp_pos(longint'(mirror_y[j]) - myj);
    endtask

    // store the circle; a closing beat relaxes the set and queues every position
    task automatic predict_relaxation(input in_item_t it);
        out_item_t o;
        if (mirror_count < SET_DEPTH)
        begin
            mirror_x[mirror_count] = it.pos_x;
            mirror_y[mirror_count] = it.pos_y;
            mirror_r[mirror_count] = it.radius;
            mirror_count++;
        end
        if (!it.last)
        begin
            return;
        end
        for (int i = 0; i < mirror_count; i++)
        begin
            for (int j = 0; j < mirror_count; j++)
            begin
                if (i != j)
                begin
                    separate_pair(i, j);
                end
            end
        end
        for (int i = 0; i < mirror_count; i++)
        begin
            o.out_x    = mirror_x[i];
            o.out_y    = mirror_y[i];
            o.out_last = (i == mirror_count - 1);
            relaxed_q.insert(relaxed_q.size(), o);
        end
        mirror_count = 0;
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offers one beat from a falling edge and holds it until busy lets it in
    task automatic send_circle(input logic signed [23:0] x, input logic signed [23:0] y,
                               input logic [15:0] r, input logic closing);
        in_item_t it;
        it.pos_x  = x;
        it.pos_y  = y;
        it.radius = r;
        it.last   = closing;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= in_item_t'({$urandom(), $urandom(), 1'b0});
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        predict_relaxation(it);
    endtask

    task automatic drop_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // a set of n circles around a centre; each axis offset stays within 2 * r_hi + 1
    task automatic send_cluster(input int n, input logic [15:0] r_hi);
        logic signed [23:0] cx, cy;
        logic        [15:0] r;
        int                 spread;
        cx = 24'($urandom());
        cy = 24'($urandom());
        for (int k = 0; k < n; k++)
        begin
            r      = 16'($urandom_range(r_hi));
            spread = r_hi * 2 + 1;
            if ($urandom_range(9) == 0)
            begin
                // stray circle anywhere in the plane
                send_circle(24'($urandom()), 24'($urandom()), 16'($urandom()), k == n - 1);
            end
            else
            begin
                send_circle(clamp_pos(longint'(cx) + $urandom_range(2 * spread) - spread),
                            clamp_pos(longint'(cy) + $urandom_range(2 * spread) - spread),
                            r, k == n - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && strobe)
        begin
            if (relaxed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat x=%0d y=%0d last=%0b",
                             result.out_x, result.out_y, result.out_last);
                end
            end
            else
            begin
                want = relaxed_q.pop_front();
                if (result.out_x !== want.out_x || result.out_y !== want.out_y
                    || result.out_last !== want.out_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected x=%0d y=%0d last=%0b,",
                                 want.out_x, want.out_y, want.out_last,
                                 " got x=%0d y=%0d last=%0b",
                                 result.out_x, result.out_y, result.out_last);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT && !timed_out)
            begin
                timed_out = 1'b1;
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic wait_drained();
        while (relaxed_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // field extremes, coincident centres, zero radii, saturation at the edges
    task automatic test_corner_sets();
        // lone circle: nothing to relax
        send_circle(24'sh7FFFFF, 24'sh800000, 16'hFFFF, 1'b1);
        // coincident centres are skipped, third circle touches both
        send_circle(24'sd1000, 24'sd1000, 16'd512, 1'b0);
        send_circle(24'sd1000, 24'sd1000, 16'd512, 1'b0);
        send_circle(24'sd1300, 24'sd1100, 16'd256, 1'b1);
        // both radii zero never touch; one zero radius takes the whole push
        send_circle(24'sd0, 24'sd0, 16'd0, 1'b0);
        send_circle(24'sd1, 24'sd0, 16'd0, 1'b0);
        send_circle(-24'sd50, 24'sd40, 16'd300, 1'b1);
        // big circles crammed against the corners force saturation
        send_circle(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b0);
        send_circle(24'sh7FFF00, 24'sh7FFFF0, 16'hFFFF, 1'b1);
        send_circle(24'sh800000, 24'sh800000, 16'hFFFF, 1'b0);
        send_circle(24'sh800100, 24'sh800000, 16'hFFFF, 1'b0);
        send_circle(24'sh800000, 24'sh800080, 16'h8000, 1'b1);
        // exact tie on contact: distance equal to the sum of radii
        send_circle(24'sd0, 24'sd0, 16'd100, 1'b0);
        send_circle(24'sd200, 24'sd0, 16'd100, 1'b0);
        send_circle(24'sd199, 24'sd1, 16'd100, 1'b1);
        // alternating bit patterns
        send_circle(24'sh555555, 24'shAAAAAA, 16'h5555, 1'b0);
        send_circle(24'shAAAAAA, 24'sh555555, 16'hAAAA, 1'b1);
        drop_start();
        wait_drained();
    endtask

    // an over-long set fills the store and is closed by a dropped beat
    task automatic test_full_store();
        for (int k = 0; k < SET_DEPTH + 2; k++)
        begin
            send_circle(24'(k * 90000 + 200000), -24'(k * 51), 16'd20, k == SET_DEPTH + 1);
        end
        drop_start();
        wait_drained();
    endtask

    // random clusters, mostly touching, at the given sender idle rate
    task automatic test_random_clusters(input int idle_pct, input int sets);
        sender_idle_pct = idle_pct;
        for (int s = 0; s < sets; s++)
        begin
            if ($urandom_range(7) == 0)
            begin
                send_cluster($urandom_range(8, 12), 16'($urandom_range(200, 3000)));
            end
            else if ($urandom_range(5) == 0)
            begin
                send_cluster($urandom_range(2, 4), 16'hFFFF);
            end
            else
            begin
                send_cluster($urandom_range(2, 6), 16'($urandom_range(16, 4000)));
            end
        end
        drop_start();
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        mirror_count    = 0;
        mismatches      = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        timed_out       = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_sets();
        test_full_store();
        test_random_clusters(24, 4);
        test_random_clusters(88, 4);
        test_random_clusters(0, 4);

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && relaxed_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
